// ===== hw/rtl/fba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants of the frame bitmap allocator: field widths,
// result status codes and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int FBA_MAX_FRAMES = 4096;
  localparam int FBA_WORD_BITS  = 32;

  localparam int FRAME_W = 12;
  localparam int CFG_W   = 13;
  localparam int STAT_W  = 3;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 13'h1000;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOCATED     = 3'd0,
    ST_HAD_FRAME     = 3'd1,
    ST_OUT_OF_FRAMES = 3'd2,
    ST_FREED         = 3'd3,
    ST_NOTHING       = 3'd4
  } fba_status_t;

  typedef struct packed {
    logic        load;
    logic        issue;
    logic        free_rd;
    logic        capture;
    logic        set_wr;
    logic        clr_wr;
    logic        res_load;
    fba_status_t res_code;
  } fba_cmd_t;

  typedef struct packed {
    logic is_free;
    logic cur_zero;
    logic free_in_range;
    logic issue_more;
    logic rd_vld;
    logic hit;
    logic out_free;
  } fba_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/frame_bitmap_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// Physical page frame allocator over a one-bit-per-frame bitmap.
// ----------------------------------------------------------------------------
// Each request word is handled alone: it is registered and then dispatched.
// A request that leaves the bitmap alone goes on to the result state; a free
// in range first reads and rewrites its bitmap word. An allocation scans the
// bitmap memory first fit, one word per cycle with a registered read, then
// sets the free bit that it found; the default size is MAX_FRAMES / WORD_BITS
// words. The next word is accepted in the cycle after the result is loaded.
// The scan covers frame_count / WORD_BITS whole words, at most MAX_FRAMES /
// WORD_BITS. The bitmap is free after reset without a clearing pass, and a
// result register lets the next request be accepted while the previous
// result waits; a new result waits for it.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator
  import fba_pkg::*;
#(
  parameter int MAX_FRAMES = FBA_MAX_FRAMES,
  parameter int WORD_BITS  = FBA_WORD_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  input  wire logic [FRAME_W-1:0] in_current_frame,
  input  wire logic               in_supervisor,
  input  wire logic               in_writable,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [FRAME_W-1:0]      out_frame_number,
  output logic                    out_present_bit,
  output logic                    out_rw_bit,
  output logic                    out_user_bit,
  output logic [STAT_W-1:0]       out_status
);

  fba_cmd_t cmd;
  fba_sts_t sts;

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fba_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req_type),
    .in_current_frame (in_current_frame),
    .in_supervisor    (in_supervisor),
    .in_writable      (in_writable),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_frame_number (out_frame_number),
    .out_present_bit  (out_present_bit),
    .out_rw_bit       (out_rw_bit),
    .out_user_bit     (out_user_bit),
    .out_status       (out_status),
    .cmd              (cmd),
    .sts              (sts)
  );

  a_present_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_present_bit == (out_status == ST_ALLOCATED)))
    else $error("present bit disagrees with status");

  a_frame_zero_without_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OUT_OF_FRAMES || out_status == ST_FREED ||
                  out_status == ST_NOTHING) |-> (out_frame_number == '0))
    else $error("nonzero frame number on a result without a frame");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result loaded over an unaccepted result");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new word accepted while a request is in progress");

endmodule
`default_nettype wire

// ===== hw/rtl/fba_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fba_datapath
// Bitmap memory with per-word valid bits, request and configuration
// registers, scan address counter, bit search and the result register.
// ----------------------------------------------------------------------------
module fba_datapath
  import fba_pkg::*;
#(
  parameter int MAX_FRAMES = FBA_MAX_FRAMES,
  parameter int WORD_BITS  = FBA_WORD_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic               in_req_type,
  input  wire logic [FRAME_W-1:0] in_current_frame,
  input  wire logic               in_supervisor,
  input  wire logic               in_writable,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [FRAME_W-1:0]      out_frame_number,
  output logic                    out_present_bit,
  output logic                    out_rw_bit,
  output logic                    out_user_bit,
  output logic [STAT_W-1:0]       out_status,
  input  wire fba_cmd_t           cmd,
  output fba_sts_t                sts
);

  localparam int NUM_WORDS = MAX_FRAMES / WORD_BITS;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = (WADDR_W + 1 > CFG_W) ? WADDR_W + 1 : CFG_W;
  localparam int IDX_W     = WADDR_W + BIT_W;
  localparam int TOTAL     = NUM_WORDS * WORD_BITS;

  function automatic logic [BIT_W-1:0] low_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] wvalid_r;

  logic [CFG_W-1:0]     frame_count_r;
  logic                 req_type_r;
  logic [FRAME_W-1:0]   cur_r;
  logic                 kern_r;
  logic                 wr_r;

  logic [WADDR_W:0]     issue_addr_r;
  logic [WADDR_W-1:0]   rd_addr_r;
  logic                 rd_vld_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rvalid_bit_r;
  logic [WORD_BITS-1:0] hit_word_r;
  logic [WADDR_W-1:0]   hit_addr_r;

  logic                 out_valid_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic                 out_present_r;
  logic                 out_rw_r;
  logic                 out_user_r;
  logic [STAT_W-1:0]    out_status_r;

  logic [CNT_W-1:0]     fc_words;
  logic [CNT_W-1:0]     limit;
  logic [WORD_BITS-1:0] rdata_eff;
  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  logic [WADDR_W-1:0]   free_addr;
  logic [BIT_W-1:0]     hit_bit;
  logic [IDX_W-1:0]     alloc_idx;
  logic                 wr_en;
  logic [WADDR_W-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  assign fc_words  = CNT_W'(frame_count_r >> BIT_W);
  assign limit     = (fc_words > CNT_W'(NUM_WORDS)) ? CNT_W'(NUM_WORDS) : fc_words;
  assign rdata_eff = rvalid_bit_r ? rdata_r : '0;
  assign free_addr = WADDR_W'(cur_r >> BIT_W);
  assign rd_en     = cmd.issue | cmd.free_rd;
  assign rd_addr   = cmd.free_rd ? free_addr : issue_addr_r[WADDR_W-1:0];
  assign hit_bit   = low_zero(hit_word_r);
  assign alloc_idx = (IDX_W'(hit_addr_r) << BIT_W) | IDX_W'(hit_bit);

  always_comb begin
    wr_en   = cmd.set_wr | cmd.clr_wr;
    wr_addr = hit_addr_r;
    wr_data = hit_word_r | (WORD_BITS'(1) << hit_bit);
    if (cmd.clr_wr) begin
      wr_addr = rd_addr_r;
      wr_data = rdata_eff & ~(WORD_BITS'(1) << cur_r[BIT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r      <= mem[rd_addr];
      rvalid_bit_r <= wvalid_r[rd_addr];
      rd_addr_r    <= rd_addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r      <= '0;
      frame_count_r <= FRAME_COUNT_RST;
      rd_vld_r      <= 1'b0;
      issue_addr_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (wr_en) begin
        wvalid_r[wr_addr] <= 1'b1;
      end
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
      if (cmd.load) begin
        issue_addr_r <= '0;
      end else if (cmd.issue) begin
        issue_addr_r <= issue_addr_r + {{WADDR_W{1'b0}}, 1'b1};
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      cur_r      <= in_current_frame;
      kern_r     <= in_supervisor;
      wr_r       <= in_writable;
    end
    if (cmd.capture) begin
      hit_word_r <= rdata_eff;
      hit_addr_r <= rd_addr_r;
    end
    if (cmd.res_load) begin
      out_status_r  <= cmd.res_code;
      out_frame_r   <= '0;
      out_present_r <= 1'b0;
      out_rw_r      <= 1'b0;
      out_user_r    <= 1'b0;
      case (cmd.res_code)
        ST_ALLOCATED: begin
          out_frame_r   <= FRAME_W'(alloc_idx);
          out_present_r <= 1'b1;
          out_rw_r      <= wr_r;
          out_user_r    <= ~kern_r;
        end
        ST_HAD_FRAME: begin
          out_frame_r <= cur_r;
        end
        default: begin
          out_frame_r <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.is_free       = (req_type_r == REQ_FREE);
    sts.cur_zero      = (cur_r == '0);
    sts.free_in_range = (32'(cur_r) < 32'(TOTAL));
    sts.issue_more    = (CNT_W'(issue_addr_r) < limit);
    sts.rd_vld        = rd_vld_r;
    sts.hit           = rd_vld_r && (rdata_eff != '1);
    sts.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_frame_number = out_frame_r;
  assign out_present_bit  = out_present_r;
  assign out_rw_bit       = out_rw_r;
  assign out_user_bit     = out_user_r;
  assign out_status       = out_status_r;

endmodule
`default_nettype wire

// ===== hw/rtl/fba_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ctrl
// Request sequencer: dispatches a word, runs the bitmap scan or the free
// read-modify-write, and hands the result code to the output register.
// ----------------------------------------------------------------------------
module fba_ctrl
  import fba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire fba_sts_t sts,
  output fba_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SET,
    S_FREE_WR,
    S_RESULT
  } state_t;

  state_t      state_r, state_nxt;
  fba_status_t res_code_r, res_code_nxt;

  always_comb begin
    state_nxt    = state_r;
    res_code_nxt = res_code_r;
    cmd          = '0;
    cmd.res_code = res_code_r;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_RESULT;
        if (!sts.is_free) begin
          if (!sts.cur_zero) begin
            res_code_nxt = ST_HAD_FRAME;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (sts.cur_zero) begin
          res_code_nxt = ST_NOTHING;
        end else if (sts.free_in_range) begin
          cmd.free_rd = 1'b1;
          state_nxt   = S_FREE_WR;
        end else begin
          res_code_nxt = ST_FREED;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SET;
        end else if (sts.issue_more) begin
          cmd.issue = 1'b1;
        end else if (!sts.rd_vld) begin
          res_code_nxt = ST_OUT_OF_FRAMES;
          state_nxt    = S_RESULT;
        end
      end
      S_SET: begin
        cmd.set_wr   = 1'b1;
        res_code_nxt = ST_ALLOCATED;
        state_nxt    = S_RESULT;
      end
      S_FREE_WR: begin
        cmd.clr_wr   = 1'b1;
        res_code_nxt = ST_FREED;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_code_r <= ST_ALLOCATED;
    end else begin
      state_r    <= state_nxt;
      res_code_r <= res_code_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== tb/frame_bitmap_allocator_test.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_test
// Self-checking testbench for the frame bitmap allocator. A queue of request
// words feeds a valid/ready driver, and a monitor compares every result word
// with a bit-accurate model of the bitmap and the scan limit. Directed words
// cover the corner cases. Random phases at several frame counts then fill the
// bitmap to exhaustion and churn it with frees, while both sides idle at
// random.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fba_pkg::*;

  localparam int NUM_WORDS = FBA_MAX_FRAMES / FBA_WORD_BITS;

  typedef struct packed {
    logic               req_type;
    logic [FRAME_W-1:0] current_frame;
    logic               supervisor;
    logic               writable;
  } page_request_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic               present;
    logic               rw;
    logic               user;
    fba_status_t        status;
  } page_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_req_type = 1'b0;
  logic [FRAME_W-1:0] in_current_frame = '0;
  logic               in_supervisor = 1'b0;
  logic               in_writable = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FRAME_W-1:0] out_frame_number;
  logic               out_present_bit;
  logic               out_rw_bit;
  logic               out_user_bit;
  logic [STAT_W-1:0]  out_status;

  bit [FBA_WORD_BITS-1:0] used_words [NUM_WORDS];
  logic [CFG_W-1:0]       frame_limit = FRAME_COUNT_RST;
  int unsigned            held_frames [$];
  page_request_t          pending_reqs [$];
  page_result_t           expected_results [$];
  int                     errors = 0;

  logic [CFG_W-1:0] phase_counts [9] = '{13'd32, 13'd64, 13'd8191, 13'd160, 13'd31,
                                         13'd4095, 13'd0, 13'd100, 13'd4096};

  frame_bitmap_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_current_frame (in_current_frame),
    .in_supervisor    (in_supervisor),
    .in_writable      (in_writable),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_number (out_frame_number),
    .out_present_bit  (out_present_bit),
    .out_rw_bit       (out_rw_bit),
    .out_user_bit     (out_user_bit),
    .out_status       (out_status)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic page_result_t allocate_or_free(page_request_t rq);
    page_result_t res;
    int unsigned  words;
    int unsigned  hit_frame;
    int           i;
    bit           found;
    res = '0;
    found = 1'b0;
    hit_frame = 0;
    words = frame_limit / FBA_WORD_BITS;
    if (words > NUM_WORDS) begin
      words = NUM_WORDS;
    end
    if (rq.req_type == REQ_ALLOC) begin
      if (rq.current_frame != '0) begin
        res.frame_number = rq.current_frame;
        res.status = ST_HAD_FRAME;
      end else begin
        for (int w = 0; w < words && !found; w++) begin
          if (used_words[w] != '1) begin
            for (int b = 0; b < FBA_WORD_BITS && !found; b++) begin
              if (!used_words[w][b]) begin
                found = 1'b1;
                hit_frame = w * FBA_WORD_BITS + b;
              end
            end
          end
        end
        if (found) begin
          used_words[hit_frame / FBA_WORD_BITS][hit_frame % FBA_WORD_BITS] = 1'b1;
          res.frame_number = hit_frame[FRAME_W-1:0];
          res.present = 1'b1;
          res.rw = rq.writable;
          res.user = !rq.supervisor;
          res.status = ST_ALLOCATED;
          if (hit_frame != 0) begin
            held_frames.push_back(hit_frame);
          end
        end else begin
          res.status = ST_OUT_OF_FRAMES;
        end
      end
    end else if (rq.current_frame == '0) begin
      res.status = ST_NOTHING;
    end else begin
      used_words[rq.current_frame / FBA_WORD_BITS][rq.current_frame % FBA_WORD_BITS] = 1'b0;
      i = 0;
      while (i < held_frames.size()) begin
        if (held_frames[i] == rq.current_frame) begin
          held_frames.delete(i);
        end else begin
          i++;
        end
      end
      res.status = ST_FREED;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  int unsigned   send_gap = 0;
  bit            send_burst = 1'b0;
  page_request_t on_bus;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(allocate_or_free(on_bus));
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() != 0) begin
          on_bus = pending_reqs.pop_front();
          in_req_type <= on_bus.req_type;
          in_current_frame <= on_bus.current_frame;
          in_supervisor <= on_bus.supervisor;
          in_writable <= on_bus.writable;
          in_valid <= 1'b1;
          if ($urandom_range(0, 31) == 0) begin
            send_burst = !send_burst;
          end
          send_gap <= send_burst ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int unsigned recv_stall = 0;
  bit          recv_burst = 1'b0;

  always @(posedge clk) begin
    page_result_t want;
    int unsigned  draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word: frame %0d status %0d",
                                  out_frame_number, out_status));
      end else begin
        want = expected_results.pop_front();
        if (out_frame_number !== want.frame_number) begin
          report_mismatch($sformatf("frame_number got %0d want %0d",
                                    out_frame_number, want.frame_number));
        end
        if (out_present_bit !== want.present) begin
          report_mismatch($sformatf("present_bit got %0b want %0b",
                                    out_present_bit, want.present));
        end
        if (out_rw_bit !== want.rw) begin
          report_mismatch($sformatf("rw_bit got %0b want %0b", out_rw_bit, want.rw));
        end
        if (out_user_bit !== want.user) begin
          report_mismatch($sformatf("user_bit got %0b want %0b", out_user_bit, want.user));
        end
        if (out_status !== want.status) begin
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        end
      end
      if ($urandom_range(0, 31) == 0) begin
        recv_burst = !recv_burst;
      end
      draw = recv_burst ? 0 : $urandom_range(0, 8);
      if (draw != 0) begin
        out_ready <= 1'b0;
        recv_stall <= draw;
      end
    end else if (recv_stall > 1) begin
      recv_stall <= recv_stall - 1;
    end else begin
      recv_stall <= 0;
      out_ready <= 1'b1;
    end
  end

  task automatic queue_request(input logic rt, input logic [FRAME_W-1:0] cf,
                               input logic kern, input logic wr);
    page_request_t rq;
    @(negedge clk);
    while (pending_reqs.size() >= 2) begin
      @(negedge clk);
    end
    rq.req_type = rt;
    rq.current_frame = cf;
    rq.supervisor = kern;
    rq.writable = wr;
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] count);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    frame_limit = count;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly allocations and frees of frames actually held, so that the bitmap
  // fills up and churns; the rest is redundant or stray requests.
  task automatic random_request();
    int unsigned        pick;
    logic [FRAME_W-1:0] target;
    pick = $urandom_range(0, 99);
    target = FRAME_W'($urandom_range(1, 4095));
    if (pick < 60) begin
      queue_request(REQ_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 80) begin
      if (held_frames.size() != 0) begin
        target = FRAME_W'(held_frames[$urandom_range(0, held_frames.size() - 1)]);
      end
      queue_request(REQ_FREE, target, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 88) begin
      queue_request(REQ_ALLOC, target, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 95) begin
      queue_request(REQ_FREE, target, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      queue_request(REQ_FREE, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(REQ_ALLOC, '0, 1'b0, 1'b0);
    queue_request(REQ_ALLOC, '0, 1'b1, 1'b1);
    queue_request(REQ_ALLOC, '0, 1'b0, 1'b1);
    queue_request(REQ_ALLOC, 12'hFFF, 1'b1, 1'b1);
    queue_request(REQ_ALLOC, 12'd1, 1'b0, 1'b1);
    queue_request(REQ_FREE, '0, 1'b1, 1'b1);
    queue_request(REQ_FREE, 12'd1, 1'b0, 1'b0);
    queue_request(REQ_FREE, 12'd1, 1'b1, 1'b0);
    queue_request(REQ_FREE, 12'hFFF, 1'b0, 1'b1);
    queue_request(REQ_ALLOC, '0, 1'b1, 1'b0);
    queue_request(REQ_FREE, 12'hAAA, 1'b1, 1'b0);
    queue_request(REQ_ALLOC, 12'h555, 1'b0, 1'b1);
    queue_request(REQ_ALLOC, '0, 1'b1, 1'b1);
    write_frame_count(13'd0);
    queue_request(REQ_ALLOC, '0, 1'b0, 1'b1);
    queue_request(REQ_FREE, 12'd2, 1'b0, 1'b0);
    write_frame_count(13'd31);
    queue_request(REQ_ALLOC, '0, 1'b1, 1'b0);
    write_frame_count(13'h1FFF);
    queue_request(REQ_ALLOC, '0, 1'b0, 1'b0);
    queue_request(REQ_ALLOC, '0, 1'b1, 1'b1);

    foreach (phase_counts[p]) begin
      write_frame_count(phase_counts[p]);
      repeat (150) random_request();
    end

    wait_idle();
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fba_pkg.sv
hw/rtl/fba_datapath.sv
hw/rtl/fba_ctrl.sv
hw/rtl/frame_bitmap_allocator.sv
tb/frame_bitmap_allocator_test.sv
